// ===== rtl/core/lsct_pkg.sv =====
// ----------------------------------------------------------------------------
// lsct_pkg
// Shared widths, tick codes, limits and types of the line sensor centroid
// tracker.
// ----------------------------------------------------------------------------
package lsct_pkg;

    // sensor array
    localparam int NSENS  = 8;
    localparam int SENS_W = $clog2(NSENS);
    localparam int SMP_W  = 16;

    // baseline accumulator and deviation total
    localparam int BASE_W = 19;
    localparam int TOT_W  = BASE_W + SENS_W;

    // calibration
    localparam int CALIB_SAMPLES = 8;
    localparam int CALIB_SHIFT   = $clog2(CALIB_SAMPLES);

    // tick counter codes
    localparam int                TICK_W       = 5;
    localparam logic [TICK_W-1:0] TICK_MAX     = 5'd31;
    localparam logic [TICK_W-1:0] CAL_FIRST    = 5'd9;
    localparam logic [TICK_W-1:0] CAL_LAST     = 5'd16;
    localparam logic [TICK_W-1:0] CAL_DIV_TICK = 5'd17;
    localparam logic [TICK_W-1:0] FOLLOW_TICK  = 5'd25;

    // drive and output widths
    localparam int DRV_W = 16;
    localparam int POS_W = 13;
    localparam int CFG_W = 10;
    localparam int STEP_W = 3;

    localparam logic [CFG_W-1:0]        BASE_DRIVE_RST = 10'd500;
    localparam logic signed [DRV_W-1:0] DRV_MAX        = 16'sh7FFF;
    localparam logic signed [DRV_W-1:0] DRV_MIN        = 16'sh8000;

    // default share scale
    localparam int SCALE_DEF = 1024;

    // samples of one request, sensor 0 in the low bits
    typedef logic [NSENS-1:0][SMP_W-1:0] t_sample_arr;

    // controls from the sequencer to the scan datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic next_dev;
        logic cal_add;
        logic cal_div;
    } t_scan_ctl;

endpackage

// ===== rtl/core/lsct_scan.sv =====
// ----------------------------------------------------------------------------
// lsct_scan
// Sample, baseline and deviation shift lines. One sensor per cycle: the
// baseline is updated, the absolute deviation formed and added to the total.
// ----------------------------------------------------------------------------
module lsct_scan (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  lsct_pkg::t_scan_ctl                     i_ctl,
    input  lsct_pkg::t_sample_arr                   i_samples,
    output logic [lsct_pkg::BASE_W-1:0]             o_dev,
    output logic [lsct_pkg::TOT_W-1:0]              o_total
);

    logic [lsct_pkg::NSENS-1:0][lsct_pkg::SMP_W-1:0]  r_smp;
    logic [lsct_pkg::NSENS-1:0][lsct_pkg::BASE_W-1:0] r_base;
    logic [lsct_pkg::NSENS-1:0][lsct_pkg::BASE_W-1:0] r_dev;
    logic [lsct_pkg::TOT_W-1:0]                       r_total;

    logic [lsct_pkg::BASE_W-1:0] w_smp_ext;
    logic [lsct_pkg::BASE_W-1:0] w_base_new;
    logic [lsct_pkg::BASE_W-1:0] w_dev;
    logic [lsct_pkg::BASE_W-1:0] w_dev_in;

    // baseline update and deviation of the head sensor
    always_comb begin
        w_smp_ext = lsct_pkg::BASE_W'(r_smp[0]);
        if (i_ctl.cal_add) begin
            w_base_new = r_base[0] + w_smp_ext;
        end else if (i_ctl.cal_div) begin
            w_base_new = r_base[0] >> lsct_pkg::CALIB_SHIFT;
        end else begin
            w_base_new = r_base[0];
        end
        if (w_smp_ext >= w_base_new) begin
            w_dev = w_smp_ext - w_base_new;
        end else begin
            w_dev = w_base_new - w_smp_ext;
        end
        w_dev_in = i_ctl.scan ? w_dev : '0;
    end

    // sample shift line
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_smp <= i_samples;
        end else if (i_ctl.scan) begin
            r_smp <= {r_smp[lsct_pkg::NSENS-1], r_smp[lsct_pkg::NSENS-1:1]};
        end
    end

    // baseline rotates once around per scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
        end else if (i_ctl.scan) begin
            r_base <= {w_base_new, r_base[lsct_pkg::NSENS-1:1]};
        end
    end

    // deviations, sensor 0 at the head once the scan is done
    always_ff @(posedge i_clk) begin
        if (i_ctl.scan || i_ctl.next_dev) begin
            r_dev <= {w_dev_in, r_dev[lsct_pkg::NSENS-1:1]};
        end
    end

    // deviation total
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_total <= '0;
        end else if (i_ctl.scan) begin
            r_total <= r_total + lsct_pkg::TOT_W'(w_dev);
        end
    end

    assign o_dev   = r_dev[0];
    assign o_total = r_total;

endmodule

// ===== rtl/core/lsct_div.sv =====
// ----------------------------------------------------------------------------
// lsct_div
// Bit-serial restoring divider for one share: floor(dev * SCALE / total).
// One quotient bit per cycle; dev must not exceed total.
// ----------------------------------------------------------------------------
module lsct_div #(
    parameter int SCALE = lsct_pkg::SCALE_DEF,
    parameter int QW    = $clog2(SCALE + 1)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [lsct_pkg::BASE_W-1:0]    i_dev,
    input  logic [lsct_pkg::TOT_W-1:0]     i_total,
    output logic                           o_done,
    output logic [QW-1:0]                  o_quot
);

    localparam int PRD_W = lsct_pkg::BASE_W + QW;
    localparam int CNT_W = $clog2(QW + 1);
    localparam logic [QW-1:0] SCALE_C = QW'(SCALE);

    logic                          r_busy;
    logic                          r_done;
    logic [CNT_W-1:0]              r_cnt;
    logic [lsct_pkg::TOT_W-1:0]    r_rem;
    logic [QW-1:0]                 r_q;

    logic [PRD_W-1:0]              w_prod;
    logic [lsct_pkg::TOT_W:0]      w_shift;
    logic [lsct_pkg::TOT_W:0]      w_diff;
    logic                          w_ge;

    // scaled dividend and one restoring step
    always_comb begin
        w_prod  = PRD_W'(i_dev) * PRD_W'(SCALE_C);
        w_shift = {r_rem, r_q[QW-1]};
        w_ge    = w_shift >= (lsct_pkg::TOT_W + 1)'(i_total);
        w_diff  = w_shift - (lsct_pkg::TOT_W + 1)'(i_total);
    end

    // iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= lsct_pkg::TOT_W'(w_prod[PRD_W-1:QW]);
            r_q   <= w_prod[QW-1:0];
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[lsct_pkg::TOT_W-1:0] : w_shift[lsct_pkg::TOT_W-1:0];
            r_q   <= {r_q[QW-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ===== rtl/core/line_sensor_centroid_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// line_sensor_centroid_tracker_unit
// Calibrates a per-sensor baseline, forms the weighted centroid of the
// deviations and steers the left and right drive values.
//
//   channel   direction  handshake                 payload
//   input     in         i_valid / o_stall         i_sample_0 .. i_sample_7
//   result    out        o_valid / i_stall         o_line_position, o_drive_left,
//                                                  o_drive_right, o_following,
//                                                  o_calibrated
//   config    in         i_base_drive_we           i_base_drive_data
//
// A new request is taken only once the last is through. The scan takes one
// sensor a cycle; each of the eight shares then goes through the one
// bit-serial divider for QW = clog2(SCALE + 1) quotient bits. The follow-mode
// tick and a zero total skip it. Reset is synchronous and clears the
// baselines in the same cycle. A stalled result holds the next one back only
// at its final step.
// ----------------------------------------------------------------------------
module line_sensor_centroid_tracker_unit #(
    parameter int SCALE = lsct_pkg::SCALE_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_base_drive_we,
    input  logic [lsct_pkg::CFG_W-1:0]          i_base_drive_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [lsct_pkg::SMP_W-1:0]          i_sample_0,
    input  logic [lsct_pkg::SMP_W-1:0]          i_sample_1,
    input  logic [lsct_pkg::SMP_W-1:0]          i_sample_2,
    input  logic [lsct_pkg::SMP_W-1:0]          i_sample_3,
    input  logic [lsct_pkg::SMP_W-1:0]          i_sample_4,
    input  logic [lsct_pkg::SMP_W-1:0]          i_sample_5,
    input  logic [lsct_pkg::SMP_W-1:0]          i_sample_6,
    input  logic [lsct_pkg::SMP_W-1:0]          i_sample_7,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [lsct_pkg::POS_W-1:0]          o_line_position,
    output logic signed [lsct_pkg::DRV_W-1:0]   o_drive_left,
    output logic signed [lsct_pkg::DRV_W-1:0]   o_drive_right,
    output logic                                o_following,
    output logic                                o_calibrated
);

    localparam int QW = $clog2(SCALE + 1);
    localparam int PW = QW + lsct_pkg::SENS_W;
    localparam int DW = lsct_pkg::DRV_W + 1;

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_DIVL = 3'd2;
    localparam logic [2:0] ST_DIVW = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    localparam logic [lsct_pkg::SENS_W-1:0] SENS_LAST = lsct_pkg::SENS_W'(lsct_pkg::NSENS - 1);

    logic [2:0]                          r_state, n_state;
    logic [lsct_pkg::SENS_W-1:0]         r_sens, n_sens;
    logic [lsct_pkg::TICK_W-1:0]         r_tick, n_tick;
    logic                                r_follow, n_follow;
    logic signed [lsct_pkg::DRV_W-1:0]   r_left, n_left;
    logic signed [lsct_pkg::DRV_W-1:0]   r_right, n_right;
    logic [lsct_pkg::CFG_W-1:0]          r_base_drive;
    logic [PW-1:0]                       r_pos, n_pos;
    logic                                r_ovalid, n_ovalid;
    logic [lsct_pkg::POS_W-1:0]          r_o_pos;
    logic signed [lsct_pkg::DRV_W-1:0]   r_o_left;
    logic signed [lsct_pkg::DRV_W-1:0]   r_o_right;
    logic                                r_o_follow;
    logic                                r_o_cal;
    logic                                w_out_load;

    logic                                w_in_acc;
    logic                                w_out_free;
    logic [lsct_pkg::TICK_W-1:0]         w_tick_inc;
    lsct_pkg::t_sample_arr               w_samples;
    lsct_pkg::t_scan_ctl                 w_ctl;
    logic [lsct_pkg::BASE_W-1:0]         w_dev;
    logic [lsct_pkg::TOT_W-1:0]          w_total;
    logic                                w_div_start;
    logic                                w_div_done;
    logic [QW-1:0]                       w_quot;
    logic [lsct_pkg::STEP_W-1:0]         w_step;
    logic signed [DW-1:0]                w_left_sum;
    logic signed [DW-1:0]                w_right_sum;
    logic signed [lsct_pkg::DRV_W-1:0]   w_left_sat;
    logic signed [lsct_pkg::DRV_W-1:0]   w_right_sat;
    logic signed [lsct_pkg::DRV_W-1:0]   w_base_s;

    assign w_samples = {i_sample_7, i_sample_6, i_sample_5, i_sample_4,
                        i_sample_3, i_sample_2, i_sample_1, i_sample_0};

    // handshakes
    assign o_stall    = (r_state != ST_IDLE);
    assign w_in_acc   = i_valid && (r_state == ST_IDLE);
    assign w_out_free = !r_ovalid || !i_stall;
    assign w_tick_inc = (r_tick == lsct_pkg::TICK_MAX) ? r_tick : r_tick + 1'b1;

    // scan datapath controls
    always_comb begin
        w_ctl.load     = w_in_acc;
        w_ctl.scan     = (r_state == ST_SCAN);
        w_ctl.next_dev = (r_state == ST_DIVW) && w_div_done;
        w_ctl.cal_add  = (r_tick >= lsct_pkg::CAL_FIRST) && (r_tick <= lsct_pkg::CAL_LAST);
        w_ctl.cal_div  = (r_tick == lsct_pkg::CAL_DIV_TICK);
    end

    assign w_div_start = (r_state == ST_DIVL) && (w_total != '0);

    lsct_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_samples (w_samples),
        .o_dev     (w_dev),
        .o_total   (w_total)
    );

    lsct_div #(
        .SCALE (SCALE),
        .QW    (QW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_dev   (w_dev),
        .i_total (w_total),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // drive step is position over scale, at most seven
    always_comb begin
        w_step = '0;
        for (int k = 1; k < lsct_pkg::NSENS; k++) begin
            if (r_pos >= PW'(k * SCALE)) begin
                w_step = lsct_pkg::STEP_W'(k);
            end
        end
    end

    // saturating drive update
    always_comb begin
        w_left_sum  = DW'(r_left) - $signed({{(DW - lsct_pkg::STEP_W){1'b0}}, w_step});
        w_right_sum = DW'(r_right) + $signed({{(DW - lsct_pkg::STEP_W){1'b0}}, w_step});
        if (w_left_sum[DW-1] != w_left_sum[DW-2]) begin
            w_left_sat = w_left_sum[DW-1] ? lsct_pkg::DRV_MIN : lsct_pkg::DRV_MAX;
        end else begin
            w_left_sat = w_left_sum[lsct_pkg::DRV_W-1:0];
        end
        if (w_right_sum[DW-1] != w_right_sum[DW-2]) begin
            w_right_sat = w_right_sum[DW-1] ? lsct_pkg::DRV_MIN : lsct_pkg::DRV_MAX;
        end else begin
            w_right_sat = w_right_sum[lsct_pkg::DRV_W-1:0];
        end
        w_base_s = $signed(lsct_pkg::DRV_W'(r_base_drive));
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_sens     = r_sens;
        n_tick     = r_tick;
        n_follow   = r_follow;
        n_left     = r_left;
        n_right    = r_right;
        n_pos      = r_pos;
        n_ovalid   = r_ovalid && i_stall;
        w_out_load = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_tick  = w_tick_inc;
                    n_pos   = '0;
                    n_sens  = '0;
                    n_state = (w_tick_inc == lsct_pkg::FOLLOW_TICK) ? ST_FIN : ST_SCAN;
                end
            end
            ST_SCAN: begin
                n_sens = r_sens + 1'b1;
                if (r_sens == SENS_LAST) begin
                    n_state = ST_DIVL;
                end
            end
            ST_DIVL: begin
                n_state = (w_total == '0) ? ST_FIN : ST_DIVW;
            end
            ST_DIVW: begin
                if (w_div_done) begin
                    n_pos = r_pos + PW'(r_sens) * PW'(w_quot);
                    if (r_sens == SENS_LAST) begin
                        n_state = ST_FIN;
                    end else begin
                        n_sens  = r_sens + 1'b1;
                        n_state = ST_DIVL;
                    end
                end
            end
            ST_FIN: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    n_ovalid   = 1'b1;
                    n_state    = ST_IDLE;
                    if (r_tick == lsct_pkg::FOLLOW_TICK) begin
                        n_follow = 1'b1;
                    end else if (r_follow) begin
                        n_left  = w_left_sat;
                        n_right = w_right_sat;
                    end else begin
                        n_left  = w_base_s;
                        n_right = w_base_s;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_sens       <= '0;
            r_tick       <= '0;
            r_follow     <= 1'b0;
            r_left       <= '0;
            r_right      <= '0;
            r_base_drive <= lsct_pkg::BASE_DRIVE_RST;
            r_ovalid     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_sens   <= n_sens;
            r_tick   <= n_tick;
            r_follow <= n_follow;
            r_left   <= n_left;
            r_right  <= n_right;
            r_ovalid <= n_ovalid;
            if (i_base_drive_we) begin
                r_base_drive <= i_base_drive_data;
            end
        end
    end

    // position accumulator
    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_o_pos    <= lsct_pkg::POS_W'(r_pos);
            r_o_left   <= n_left;
            r_o_right  <= n_right;
            r_o_follow <= n_follow;
            r_o_cal    <= (r_tick >= lsct_pkg::CAL_DIV_TICK);
        end
    end

    assign o_valid         = r_ovalid;
    assign o_line_position = r_o_pos;
    assign o_drive_left    = r_o_left;
    assign o_drive_right   = r_o_right;
    assign o_following     = r_o_follow;
    assign o_calibrated    = r_o_cal;

    // a new result only comes out of the final step
    a_valid_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state) == ST_FIN)
        else $error("result valid rose outside the final step");

    // follow mode, once entered, is kept
    a_follow_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_follow |=> r_follow)
        else $error("follow mode dropped");

    // the follow-mode tick leaves both drives alone
    a_follow_tick_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_load && (r_tick == lsct_pkg::FOLLOW_TICK)) |=>
            ($stable(r_left) && $stable(r_right) && r_follow))
        else $error("drives changed on the follow-mode tick");

    // divider is only started while the sequencer waits on a share
    a_div_done_ctx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |=> (r_state == ST_DIVW) && !w_div_done)
        else $error("divider start out of sequence");

endmodule

// ===== dv/lsct_track_checker.sv =====
// ----------------------------------------------------------------------------
// lsct_track_checker
// Watches the request, result and base drive ports of the line sensor
// centroid tracker, predicts every result from its own copy of the tracker
// state and compares each returned result field by field in request order.
// ----------------------------------------------------------------------------
module lsct_track_checker #(
    parameter int SCALE = lsct_pkg::SCALE_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lsct_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                                i_req_valid,
    input  logic                                i_req_stall,
    input  lsct_pkg::t_sample_arr               i_samples,
    input  logic                                i_res_valid,
    input  logic                                i_res_stall,
    input  logic [lsct_pkg::POS_W-1:0]          i_line_position,
    input  logic signed [lsct_pkg::DRV_W-1:0]   i_drive_left,
    input  logic signed [lsct_pkg::DRV_W-1:0]   i_drive_right,
    input  logic                                i_following,
    input  logic                                i_calibrated,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    import lsct_pkg::*;

    typedef struct packed {
        logic [POS_W-1:0]        line_position;
        logic signed [DRV_W-1:0] drive_left;
        logic signed [DRV_W-1:0] drive_right;
        logic                    following;
        logic                    calibrated;
    } t_track_result;

    // tracker state as the block should hold it
    logic [TICK_W-1:0]       trk_tick;
    logic [BASE_W-1:0]       trk_baseline [NSENS];
    logic                    trk_follow;
    logic signed [DRV_W-1:0] trk_left;
    logic signed [DRV_W-1:0] trk_right;
    logic [CFG_W-1:0]        trk_base_drive;

    // results still owed by the block, oldest first
    t_track_result           expected_track [$];
    int                      n_fail = 0;

    // clamp to the signed drive range
    function automatic logic signed [DRV_W-1:0] sat_drive(input int value);
        if (value > int'(DRV_MAX)) return DRV_MAX;
        if (value < int'(DRV_MIN)) return DRV_MIN;
        return DRV_W'(value);
    endfunction

    // one tick of the tracker: calibration, centroid and drive update
    function automatic t_track_result advance_tracker(input t_sample_arr smp);
        t_track_result     res;
        logic [BASE_W-1:0] dev [NSENS];
        logic [TOT_W-1:0]  total;
        longint unsigned   share;
        int                pos_sum;
        int                drive_step;
        int                i;
        res     = '0;
        total   = '0;
        pos_sum = 0;
        if (trk_tick != TICK_MAX) trk_tick = trk_tick + 1'b1;

        // baseline accumulation, then averaging on the divide tick
        if (trk_tick >= CAL_FIRST && trk_tick <= CAL_LAST) begin
            for (i = 0; i < NSENS; i++)
                trk_baseline[i] = trk_baseline[i] + BASE_W'(smp[i]);
        end else if (trk_tick == CAL_DIV_TICK) begin
            for (i = 0; i < NSENS; i++)
                trk_baseline[i] = BASE_W'(trk_baseline[i] / CALIB_SAMPLES);
        end

        if (trk_tick == FOLLOW_TICK) begin
            // mode switch only, drives hold
            trk_follow = 1'b1;
        end else begin
            for (i = 0; i < NSENS; i++) begin
                dev[i] = (BASE_W'(smp[i]) >= trk_baseline[i]) ?
                         BASE_W'(smp[i]) - trk_baseline[i] :
                         trk_baseline[i] - BASE_W'(smp[i]);
                total  = total + TOT_W'(dev[i]);
            end
            // weighted centroid of the scaled shares, zero when nothing deviates
            if (total != '0) begin
                for (i = 0; i < NSENS; i++) begin
                    share   = (64'(dev[i]) * 64'(SCALE)) / 64'(total);
                    pos_sum = pos_sum + i * int'(share);
                end
            end
            drive_step = pos_sum / SCALE;
            trk_left   = sat_drive(int'(trk_left) - drive_step);
            trk_right  = sat_drive(int'(trk_right) + drive_step);
            if (!trk_follow) begin
                trk_left  = DRV_W'(trk_base_drive);
                trk_right = DRV_W'(trk_base_drive);
            end
        end

        res.line_position = POS_W'(pos_sum);
        res.drive_left    = trk_left;
        res.drive_right   = trk_right;
        res.following     = trk_follow;
        res.calibrated    = (trk_tick >= CAL_DIV_TICK);
        return res;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            n_fail++;
        end
    endtask

    // compare returned results, then track config writes and new requests
    always @(posedge i_clk) begin
        t_track_result want;
        if (!i_rst_n) begin
            trk_tick       = '0;
            trk_follow     = 1'b0;
            trk_left       = '0;
            trk_right      = '0;
            trk_base_drive = BASE_DRIVE_RST;
            for (int i = 0; i < NSENS; i++) trk_baseline[i] = '0;
            expected_track.delete();
        end else begin
            if (i_res_valid && !i_res_stall) begin
                if (expected_track.size() == 0) begin
                    $error("result with no request pending");
                    n_fail++;
                end else begin
                    want = expected_track.pop_front();
                    check_field("line_position", want.line_position, i_line_position);
                    check_field("drive_left", want.drive_left, i_drive_left);
                    check_field("drive_right", want.drive_right, i_drive_right);
                    check_field("following", want.following, i_following);
                    check_field("calibrated", want.calibrated, i_calibrated);
                end
            end
            if (i_cfg_we) trk_base_drive = i_cfg_data;
            if (i_req_valid && !i_req_stall)
                expected_track.push_back(advance_tracker(i_samples));
        end
        o_fail_count <= n_fail;
        o_pending    <= expected_track.size();
    end

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives the line sensor centroid tracker through calibration, the switch
// into follow mode and a long random run, writes the base drive between
// phases, and finishes with a sweep at the largest drive step.
// Both handshakes idle at random; the result side holds off once for long.
// ----------------------------------------------------------------------------
module tb;
    import lsct_pkg::*;

    localparam int               N_RANDOM    = 1025;
    localparam int               N_SWEEP     = 200;
    localparam int               HOLD_CYCLES = 3000;
    localparam int               CYCLE_LIMIT = 5_000_000;
    localparam int               DRAIN_WAIT  = 120;
    localparam logic [SMP_W-1:0] SMP_MAX     = '1;

    logic                    clk             = 1'b0;
    logic                    rst_n           = 1'b0;
    logic                    base_drive_we   = 1'b0;
    logic [CFG_W-1:0]        base_drive_data = '0;
    logic                    req_valid       = 1'b0;
    t_sample_arr             req_samples     = '0;
    logic                    res_stall       = 1'b0;

    logic                    req_stall;
    logic                    res_valid;
    logic [POS_W-1:0]        line_position;
    logic signed [DRV_W-1:0] drive_left;
    logic signed [DRV_W-1:0] drive_right;
    logic                    following;
    logic                    calibrated;

    int                      fail_count;
    int                      pending;
    int                      cycle_count = 0;

    // stimulus bookkeeping: ticks sent and the baseline they build
    int                      n_sent = 0;
    logic [BASE_W-1:0]       cal_sum [NSENS] = '{default: '0};
    t_sample_arr             cal_level = '0;
    logic                    calm      = 1'b0;
    logic                    hold_go   = 1'b0;
    logic                    hold_done = 1'b0;

    line_sensor_centroid_tracker_unit u_dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_base_drive_we   (base_drive_we),
        .i_base_drive_data (base_drive_data),
        .i_valid           (req_valid),
        .o_stall           (req_stall),
        .i_sample_0        (req_samples[0]),
        .i_sample_1        (req_samples[1]),
        .i_sample_2        (req_samples[2]),
        .i_sample_3        (req_samples[3]),
        .i_sample_4        (req_samples[4]),
        .i_sample_5        (req_samples[5]),
        .i_sample_6        (req_samples[6]),
        .i_sample_7        (req_samples[7]),
        .o_valid           (res_valid),
        .i_stall           (res_stall),
        .o_line_position   (line_position),
        .o_drive_left      (drive_left),
        .o_drive_right     (drive_right),
        .o_following       (following),
        .o_calibrated      (calibrated)
    );

    lsct_track_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (base_drive_we),
        .i_cfg_data      (base_drive_data),
        .i_req_valid     (req_valid),
        .i_req_stall     (req_stall),
        .i_samples       (req_samples),
        .i_res_valid     (res_valid),
        .i_res_stall     (res_stall),
        .i_line_position (line_position),
        .i_drive_left    (drive_left),
        .i_drive_right   (drive_right),
        .i_following     (following),
        .i_calibrated    (calibrated),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // clock
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        forever begin
            @(posedge clk);
            if (hold_go && !hold_done) begin
                hold_done = 1'b1;
                res_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                res_stall <= !calm && ($urandom_range(99) < 20);
            end
        end
    end

    function automatic t_sample_arr fill_item(input logic [SMP_W-1:0] value);
        return {NSENS{value}};
    endfunction

    function automatic t_sample_arr random_item();
        return {$urandom(), $urandom(), $urandom(), $urandom()};
    endfunction

    // every sensor at its baseline except one
    function automatic t_sample_arr lone_item(input int idx, input logic [SMP_W-1:0] value);
        t_sample_arr smp;
        smp      = cal_level;
        smp[idx] = value;
        return smp;
    endfunction

    function automatic logic [SMP_W-1:0] off_level(input logic [SMP_W-1:0] level);
        logic [SMP_W-1:0] value;
        do value = SMP_W'($urandom_range(65535)); while (value == level);
        return value;
    endfunction

    // small or large step away from the baseline, clipped to the sample range
    function automatic logic [SMP_W-1:0] nudge(input logic [SMP_W-1:0] level);
        int delta;
        int value;
        delta = $urandom_range(1) ? int'($urandom_range(255, 1)) : int'($urandom_range(65535, 1));
        value = $urandom_range(1) ? int'(level) + delta : int'(level) - delta;
        if (value > 65535) value = 65535;
        if (value < 0) value = 0;
        return SMP_W'(value);
    endfunction

    // mostly baseline-relative patterns, with raw noise and extremes mixed in
    function automatic t_sample_arr mixed_item();
        t_sample_arr smp;
        int          kind;
        int          n;
        int          i;
        int          idx;
        kind = $urandom_range(99);
        smp  = cal_level;
        if (kind < 40) begin
            n = $urandom_range(3, 1);
            for (i = 0; i < n; i++) begin
                idx      = $urandom_range(NSENS - 1);
                smp[idx] = nudge(cal_level[idx]);
            end
        end else if (kind < 55) begin
            idx      = $urandom_range(NSENS - 1);
            smp[idx] = off_level(cal_level[idx]);
        end else if (kind < 75) begin
            smp = random_item();
        end else if (kind < 90) begin
            for (i = 0; i < NSENS; i++) begin
                case ($urandom_range(3))
                    0: smp[i] = '0;
                    1: smp[i] = SMP_MAX;
                    2: smp[i] = cal_level[i];
                    default: smp[i] = SMP_W'($urandom_range(65535));
                endcase
            end
        end
        return smp;
    endfunction

    // offer one request and hold it until it is taken
    task automatic send_item(input t_sample_arr smp);
        int i;
        if (!calm && $urandom_range(99) < 5) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(120, 1)) @(posedge clk);
        end
        while (!calm && $urandom_range(99) < 20) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid   <= 1'b1;
        req_samples <= smp;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        n_sent++;
        if (n_sent >= CAL_FIRST && n_sent <= CAL_LAST) begin
            for (i = 0; i < NSENS; i++) cal_sum[i] = cal_sum[i] + BASE_W'(smp[i]);
        end
        if (n_sent == CAL_DIV_TICK) begin
            for (i = 0; i < NSENS; i++) cal_level[i] = SMP_W'(cal_sum[i] / CALIB_SAMPLES);
        end
    endtask

    // stop offering and wait for every owed result
    task automatic settle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_base_drive(input logic [CFG_W-1:0] value);
        settle();
        base_drive_we   <= 1'b1;
        base_drive_data <= value;
        @(posedge clk);
        base_drive_we   <= 1'b0;
    endtask

    // stimulus and verdict
    initial begin
        t_sample_arr smp;
        int          k;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // before calibration: zero total, equal shares, weight at either end
        send_item(fill_item('0));
        send_item(fill_item(SMP_MAX));
        send_item(lone_item(7, SMP_MAX));
        write_base_drive('0);
        send_item(lone_item(0, SMP_MAX));
        send_item(random_item());
        write_base_drive('1);
        send_item(random_item());
        for (k = 0; k < NSENS; k++) smp[k] = k[0] ? 16'hAAAA : 16'h5555;
        send_item(smp);
        send_item(random_item());

        // calibration ticks: sensor 0 pinned high, sensor 1 pinned low
        for (k = 0; k < CALIB_SAMPLES; k++) begin
            if (k == 4) write_base_drive(10'd1);
            smp    = random_item();
            smp[0] = SMP_MAX;
            smp[1] = '0;
            send_item(smp);
        end

        // divide tick, then against the finished baseline
        send_item(random_item());
        send_item(cal_level);
        smp    = cal_level;
        smp[0] = '0;
        smp[1] = SMP_MAX;
        send_item(smp);
        send_item(fill_item('0));
        send_item(fill_item(SMP_MAX));
        send_item(lone_item(7, off_level(cal_level[7])));
        send_item(random_item());
        write_base_drive(10'd1000);
        send_item(random_item());
        // follow tick keeps the drives of the tick before
        write_base_drive(10'd7);
        send_item(random_item());

        // random run with a long hold-off and a stretch without idling
        for (k = 0; k < N_RANDOM; k++) begin
            if (k == 200) hold_go <= 1'b1;
            calm <= (k >= 600 && k < 800);
            send_item(mixed_item());
        end

        // full weight on the last sensor, largest drive step every tick
        for (k = 0; k < N_SWEEP; k++) send_item(lone_item(7, off_level(cal_level[7])));

        settle();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
